### design/prefix_trie_insert_lookup_assert.svh
// Assertion macros used by the trie lookup design file.
`ifndef PREFIX_TRIE_INSERT_LOOKUP_ASSERT_SVH
`define PREFIX_TRIE_INSERT_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PTIL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PTIL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTIL_ASSERT_NOW(lbl, ante, cons, msg)
`define PTIL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/ptil_pkg.sv
// Types and constants of the trie insert and lookup block.
`default_nettype none
package ptil_pkg;
	localparam int NODE_COUNT    = 1024;
	localparam int ALPHABET_SIZE = 26;
	localparam int NODE_W        = $clog2(NODE_COUNT);
	localparam int LET_W         = 5;
	localparam int FN_W          = 2;

	localparam logic [NODE_W-1:0] ROOT_NODE = NODE_W'(1);
	localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);

	localparam logic [FN_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FN_W-1:0] FN_SEARCH = 2'd1;
	localparam logic [FN_W-1:0] FN_PREFIX = 2'd2;

	typedef logic [NODE_W-1:0] node_t;

	// One child slot: the child number and the word end mark of that child.
	typedef struct packed {
		logic  mark;
		node_t child;
	} slot_t;

	typedef slot_t [ALPHABET_SIZE-1:0] row_t;

	typedef struct packed {
		logic  en;
		node_t addr;
		row_t  data;
	} wr_req_t;
endpackage
`default_nettype wire

### design/prefix_trie_insert_lookup.sv
// Trie insert, exact search and prefix test, one letter per beat.
// A result beat passes through the work stage (act_s1) and then the done register.
// No new item is taken while the last one is in the work stage, set by the node row read and its write-back.
// Results cannot be stalled: done is high for one cycle, found and pool_full valid with it.
// After arst_n is released, busy stays high while the row store
// is cleared; the walk restarts at the root.
`default_nettype none
`include "prefix_trie_insert_lookup_assert.svh"
module prefix_trie_insert_lookup import ptil_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [FN_W-1:0] func,
	input  wire logic [LET_W-1:0] letter,
	input  wire logic            last_letter,
	input  wire logic            empty_word,
	output logic                 done,
	output logic                 found,
	output logic                 pool_full
);
	logic             accept;
	logic             clearing;
	row_t             rd_row;
	wr_req_t          wr;

	logic             act_s1;
	logic [FN_W-1:0]  func_s1;
	logic [LET_W-1:0] letter_s1;
	logic             last_s1;
	logic             empty_s1;

	node_t            walk_node_q;
	node_t            walk_par_q;
	logic [LET_W-1:0] walk_let_q;
	logic             walk_mark_q;
	logic             walk_fail_q;
	logic             ovf_q;
	node_t            nodes_used_q;
	logic             root_mark_q;

	logic             done_q;
	logic             found_q;
	logic             pool_q;

	node_t            n_node;
	node_t            n_par;
	logic [LET_W-1:0] n_let;
	logic             n_mark;
	logic             n_fail;
	logic             n_ovf;
	node_t            n_used;
	logic             n_root_mark;
	slot_t            sel;
	row_t             wr_row;
	logic             wr_en;
	logic             word_end;
	logic             res_found;

	assign busy   = clearing | act_s1;
	assign accept = start & ~busy;

	ptil_row_ram u_rows (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (empty_word ? walk_par_q : walk_node_q),
		.rd_row   (rd_row),
		.wr       (wr),
		.clearing (clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1   <= func;
			letter_s1 <= letter;
			last_s1   <= last_letter;
			empty_s1  <= empty_word;
		end
	end

	// Step the walk by one letter on the fetched row, then close the word if asked.
	always_comb begin
		n_node      = walk_node_q;
		n_par       = walk_par_q;
		n_let       = walk_let_q;
		n_mark      = (walk_node_q == ROOT_NODE) ? root_mark_q : walk_mark_q;
		n_fail      = walk_fail_q;
		n_ovf       = ovf_q;
		n_used      = nodes_used_q;
		n_root_mark = root_mark_q;
		sel         = '0;
		wr_row      = rd_row;
		wr_en       = 1'b0;
		res_found   = 1'b0;
		word_end    = last_s1 | empty_s1;

		if (!empty_s1 && !walk_fail_q) begin
			if (letter_s1 >= LET_W'(ALPHABET_SIZE)) begin
				n_fail = 1'b1;
			end else begin
				sel = rd_row[letter_s1];
				if (sel.child == '0) begin
					if (func_s1 != FN_INSERT) begin
						n_fail = 1'b1;
					end else if (nodes_used_q == LAST_NODE) begin
						n_ovf  = 1'b1;
						n_fail = 1'b1;
					end else begin
						n_used            = nodes_used_q + NODE_W'(1);
						sel.child         = n_used;
						sel.mark          = 1'b0;
						wr_row[letter_s1] = sel;
						wr_en             = 1'b1;
					end
				end
				if (!n_fail) begin
					n_par  = walk_node_q;
					n_let  = letter_s1;
					n_node = sel.child;
					n_mark = sel.mark;
				end
			end
		end

		if (word_end) begin
			unique case (func_s1)
				FN_INSERT: begin
					res_found = ~n_fail;
					if (!n_fail) begin
						if (n_node == ROOT_NODE) begin
							n_root_mark = 1'b1;
						end else begin
							// The mark lives in the parent's row, which is the row fetched.
							wr_row[n_let].mark = 1'b1;
							wr_en              = 1'b1;
						end
					end
				end
				FN_SEARCH: res_found = ~n_fail & n_mark;
				default:   res_found = ~n_fail;
			endcase
		end
	end

	assign wr.en   = act_s1 & wr_en;
	assign wr.addr = empty_s1 ? walk_par_q : walk_node_q;
	assign wr.data = wr_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_node_q  <= ROOT_NODE;
			walk_par_q   <= ROOT_NODE;
			walk_let_q   <= '0;
			walk_mark_q  <= 1'b0;
			walk_fail_q  <= 1'b0;
			ovf_q        <= 1'b0;
			nodes_used_q <= ROOT_NODE;
			root_mark_q  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= act_s1 & word_end;
			if (act_s1) begin
				nodes_used_q <= n_used;
				root_mark_q  <= n_root_mark;
				walk_par_q   <= n_par;
				walk_let_q   <= n_let;
				walk_mark_q  <= n_mark;
				if (word_end) begin
					walk_node_q <= ROOT_NODE;
					walk_fail_q <= 1'b0;
					ovf_q       <= 1'b0;
				end else begin
					walk_node_q <= n_node;
					walk_fail_q <= n_fail;
					ovf_q       <= n_ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act_s1 && word_end) begin
			found_q <= res_found;
			pool_q  <= n_ovf;
		end
	end

	assign done      = done_q;
	assign found     = found_q;
	assign pool_full = pool_q;

	`PTIL_ASSERT_NEXT(a_accept_works, accept, act_s1, "accepted item did not enter the work stage")
	`PTIL_ASSERT_NOW(a_done_from_work, done, $past(act_s1), "result beat without a worked item")
	`PTIL_ASSERT_NOW(a_pool_grows_in_work, !$stable(nodes_used_q), $past(act_s1),
		"node count changed outside the work cycle")
	`PTIL_ASSERT_NOW(a_walk_restarts, done, walk_node_q == ROOT_NODE && !walk_fail_q && !ovf_q,
		"walk not back at the root after a result")
endmodule
`default_nettype wire

### design/ptil_row_ram.sv
// Row store of the trie: one row of child slots per node, cleared after reset.
`default_nettype none
module ptil_row_ram import ptil_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    rd_en,
	input  wire node_t   rd_addr,
	output row_t         rd_row,
	input  wire wr_req_t wr,
	output logic         clearing
);
	row_t  mem [NODE_COUNT];
	row_t  rd_q;
	node_t clr_addr_q;
	logic  clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + NODE_W'(1);
			if (clr_addr_q == LAST_NODE) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Sweep zeros through every row, then hand the port to the walk logic.
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_row   = rd_q;
	assign clearing = clr_q;
endmodule
`default_nettype wire

### sim/trie_walk_checker.sv
`timescale 1ns / 100ps
// Trie walk checker: predicts the verdict of each word and compares it with the done beats.
module trie_walk_checker import ptil_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic [FN_W-1:0] func,
	input  logic [LET_W-1:0] letter,
	input  logic            last_letter,
	input  logic            empty_word,
	input  logic            done,
	input  logic            found,
	input  logic            pool_full,
	output int              errors,
	output int              pending
);
	typedef struct packed {
		logic found;
		logic pool_full;
	} verdict_t;

	node_t       kids [NODE_COUNT][ALPHABET_SIZE];
	bit          word_ends [NODE_COUNT];
	int unsigned nodes_taken;
	node_t       at_node;
	bit          walk_lost;
	bit          ran_out;
	verdict_t    verdicts_due [$];

	task automatic report_mismatch(input string what, input logic want, input logic got);
		$display("mismatch at %0t ns: %s expected %0b got %0b", $time, what, want, got);
		errors++;
	endtask

	// Advance the walk by one beat; return 1 when the beat closes a word.
	function automatic bit trie_take_item(input logic [FN_W-1:0] fn, input logic [LET_W-1:0] ltr,
			input logic lst, input logic emp, output verdict_t v);
		node_t nxt;
		v = '0;
		if (!emp && !walk_lost) begin
			if (ltr >= ALPHABET_SIZE) begin
				walk_lost = 1'b1;
			end else begin
				nxt = kids[at_node][ltr];
				if (nxt == '0) begin
					if (fn != FN_INSERT) begin
						walk_lost = 1'b1;
					end else if (nodes_taken + 1 >= NODE_COUNT) begin
						ran_out   = 1'b1;
						walk_lost = 1'b1;
					end else begin
						nodes_taken++;
						nxt = node_t'(nodes_taken);
						kids[at_node][ltr] = nxt;
					end
				end
				if (!walk_lost)
					at_node = nxt;
			end
		end
		if (!lst && !emp)
			return 1'b0;
		case (fn)
			FN_INSERT: begin
				if (!walk_lost)
					word_ends[at_node] = 1'b1;
				v.found = !walk_lost;
			end
			FN_SEARCH: v.found = !walk_lost && word_ends[at_node];
			default:   v.found = !walk_lost;
		endcase
		v.pool_full = ran_out;
		at_node     = ROOT_NODE;
		walk_lost   = 1'b0;
		ran_out     = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t due;
		verdict_t v;
		if (!arst_n) begin
			foreach (kids[n, l])
				kids[n][l] = '0;
			foreach (word_ends[n])
				word_ends[n] = 1'b0;
			nodes_taken = ROOT_NODE;
			at_node     = ROOT_NODE;
			walk_lost   = 1'b0;
			ran_out     = 1'b0;
			verdicts_due.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch("done beat with no word pending", 1'b0, 1'b1);
				end else begin
					due = verdicts_due.pop_front();
					if (found !== due.found)
						report_mismatch("found", due.found, found);
					if (pool_full !== due.pool_full)
						report_mismatch("pool_full", due.pool_full, pool_full);
				end
			end
			if (start && !busy)
				if (trie_take_item(func, letter, last_letter, empty_word, v))
					verdicts_due = {verdicts_due, v};
			pending = verdicts_due.size();
		end
	end
endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the trie testbench: clock, reset, letter stimulus and the final verdict.
module tb_top;
	import ptil_pkg::*;

	// Unused operation code, handled by the block as a prefix test.
	localparam logic [FN_W-1:0] FN_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int WORD_MAX    = 12;
	localparam int BANK_SIZE   = 32;

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic [FN_W-1:0]  func        = '0;
	logic [LET_W-1:0] letter      = '0;
	logic             last_letter = 1'b0;
	logic             empty_word  = 1'b0;
	logic             busy;
	logic             done;
	logic             found;
	logic             pool_full;

	int mismatches;
	int pending;
	int cycle_count = 0;
	int items_sent  = 0;
	bit gaps_on     = 1'b1;

	logic [LET_W-1:0] word_buf [WORD_MAX];
	logic [LET_W-1:0] bank [BANK_SIZE][WORD_MAX];
	int               bank_len [BANK_SIZE];
	int               bank_fill = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	prefix_trie_insert_lookup u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.letter      (letter),
		.last_letter (last_letter),
		.empty_word  (empty_word),
		.done        (done),
		.found       (found),
		.pool_full   (pool_full)
	);

	trie_walk_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.letter      (letter),
		.last_letter (last_letter),
		.empty_word  (empty_word),
		.done        (done),
		.found       (found),
		.pool_full   (pool_full),
		.errors      (mismatches),
		.pending     (pending)
	);

	// Present one beat, with an optional idle burst ahead of it, and hold until taken.
	task automatic send_item(input logic [FN_W-1:0] fn, input logic [LET_W-1:0] ltr,
			input logic lst, input logic emp);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				start       = 1'b0;
				func        = FN_W'($urandom);
				letter      = LET_W'($urandom);
				last_letter = 1'($urandom);
				empty_word  = 1'($urandom);
			end
		end
		@(negedge clk);
		start       = 1'b1;
		func        = fn;
		letter      = ltr;
		last_letter = lst;
		empty_word  = emp;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// One random word; searches and prefix tests often reuse a stored word so they hit.
	task automatic random_word();
		int len;
		int pick;
		int span;
		int slot;
		logic [FN_W-1:0] fn;
		bit from_bank;
		pick = $urandom_range(0, 99);
		fn = pick < 40 ? FN_INSERT : pick < 70 ? FN_SEARCH : pick < 93 ? FN_PREFIX : FN_SPARE;
		from_bank = fn != FN_INSERT && bank_fill > 0 && $urandom_range(0, 9) < 6;
		if (from_bank) begin
			pick = $urandom_range(0, bank_fill - 1);
			len  = bank_len[pick];
			if (fn != FN_SEARCH)
				len = $urandom_range(1, len);
			for (int i = 0; i < len; i++)
				word_buf[i] = bank[pick][i];
			if ($urandom_range(0, 4) == 0)
				word_buf[len-1] = LET_W'($urandom_range(0, 3));
		end else begin
			len  = $urandom_range(0, 32) == 0 ? 0 : $urandom_range(1, 6);
			span = $urandom_range(0, 9) < 7 ? 3 : ALPHABET_SIZE - 1;
			for (int i = 0; i < len; i++)
				word_buf[i] = LET_W'($urandom_range(0, span));
			if (len > 0 && $urandom_range(0, 29) == 0)
				word_buf[$urandom_range(0, len - 1)] = LET_W'($urandom_range(ALPHABET_SIZE, 31));
		end
		if (fn == FN_INSERT && len > 0) begin
			if (bank_fill < BANK_SIZE) begin
				slot = bank_fill;
				bank_fill++;
			end else begin
				slot = $urandom_range(0, BANK_SIZE - 1);
			end
			bank_len[slot] = len;
			for (int i = 0; i < len; i++)
				bank[slot][i] = word_buf[i];
		end
		if (len == 0) begin
			send_item(fn, LET_W'($urandom), 1'($urandom), 1'b1);
			return;
		end
		for (int i = 0; i < len; i++) begin
			// Cut the word short now and then with an empty-word beat.
			if (i < len - 1 && $urandom_range(0, 39) == 0) begin
				send_item(fn, LET_W'($urandom), 1'($urandom), 1'b1);
				return;
			end
			send_item((i < len - 1 && $urandom_range(0, 19) == 0) ? FN_W'($urandom_range(0, 3)) : fn,
				word_buf[i], i == len - 1, 1'b0);
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Empty words against the root.
		send_item(FN_SEARCH, 5'd0, 1'b0, 1'b1);
		send_item(FN_PREFIX, 5'd31, 1'b1, 1'b1);
		send_item(FN_INSERT, 5'd0, 1'b0, 1'b1);
		send_item(FN_SEARCH, 5'd0, 1'b1, 1'b1);
		// Single letters at both ends of the alphabet.
		send_item(FN_INSERT, 5'd25, 1'b1, 1'b0);
		send_item(FN_SEARCH, 5'd0, 1'b1, 1'b0);
		send_item(FN_SPARE, 5'd25, 1'b1, 1'b0);
		// Stored word versus stored prefix.
		send_item(FN_INSERT, 5'd0, 1'b0, 1'b0);
		send_item(FN_INSERT, 5'd1, 1'b1, 1'b0);
		send_item(FN_SEARCH, 5'd0, 1'b1, 1'b0);
		send_item(FN_PREFIX, 5'd0, 1'b1, 1'b0);
		// Letters past the alphabet.
		send_item(FN_INSERT, 5'd2, 1'b0, 1'b0);
		send_item(FN_INSERT, 5'd31, 1'b1, 1'b0);
		send_item(FN_SEARCH, 5'd26, 1'b1, 1'b0);
		// Insert letter followed by a search letter within one word.
		send_item(FN_INSERT, 5'd16, 1'b0, 1'b0);
		send_item(FN_SEARCH, 5'd17, 1'b1, 1'b0);
		// Empty-word beat in the middle of a word.
		send_item(FN_SEARCH, 5'd0, 1'b0, 1'b0);
		send_item(FN_SEARCH, 5'd0, 1'b0, 1'b1);
		send_item(FN_INSERT, 5'd0, 1'b0, 1'b0);
		send_item(FN_INSERT, 5'd5, 1'b0, 1'b1);
		send_item(FN_SEARCH, 5'd0, 1'b1, 1'b0);
		// Letters after the walk has left the stored paths.
		send_item(FN_PREFIX, 5'd24, 1'b0, 1'b0);
		send_item(FN_PREFIX, 5'd1, 1'b0, 1'b0);
		send_item(FN_PREFIX, 5'd2, 1'b1, 1'b0);

		while (items_sent < 420)
			random_word();

		// Long words over the whole alphabet to drain the node pool.
		repeat (80) begin
			for (int i = 0; i < WORD_MAX; i++)
				send_item(FN_INSERT, LET_W'($urandom_range(0, ALPHABET_SIZE - 1)),
					i == WORD_MAX - 1, 1'b0);
		end

		gaps_on = 1'b0;
		while (items_sent < 1450)
			random_word();

		@(negedge clk);
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
